>>> rtl/hid_motion_report_scheduler_defines.svh
// Assertion macros used by the RTL of the motion report scheduler.
`ifndef HID_MOTION_REPORT_SCHEDULER_DEFINES_SVH
`define HID_MOTION_REPORT_SCHEDULER_DEFINES_SVH

// Checked only while the block is out of reset.
`define HMRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HMRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/hmrs_pkg.sv
package hmrs_pkg;

    localparam int NUM_KEYS       = 12;
    localparam int REPORT_BUTTONS = 32;
    localparam int KEY_POS_W      = 5;
    localparam int KEY_MAP_W      = NUM_KEYS * KEY_POS_W;
    localparam int TIME_W         = 32;
    localparam int AXIS_W         = 16;
    localparam int NUM_AXES       = 3;
    localparam int PERIOD_W       = 8;
    localparam int REPEAT_W       = 4;
    localparam int ID_W           = 2;
    localparam int LEN_W          = 3;
    localparam int PAYLOAD_W      = 48;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 60;

    localparam int IN_FIELDS_W    = TIME_W + 2 * NUM_AXES * AXIS_W + NUM_KEYS;
    localparam int IN_DATA_W      = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W   = LEN_W + PAYLOAD_W;
    localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W     = 1 + ID_W;

    localparam logic [PERIOD_W-1:0]  RST_UPDATE_PERIOD = PERIOD_W'(8);
    localparam logic [REPEAT_W-1:0]  RST_ZERO_REPEAT   = REPEAT_W'(3);

    localparam logic [ID_W-1:0] RPT_NONE  = 2'd0;
    localparam logic [ID_W-1:0] RPT_TRANS = 2'd1;
    localparam logic [ID_W-1:0] RPT_ROT   = 2'd2;
    localparam logic [ID_W-1:0] RPT_KEYS  = 2'd3;

    localparam logic [LEN_W-1:0] MOTION_LEN = LEN_W'(6);
    localparam logic [LEN_W-1:0] KEYS_LEN   = LEN_W'(REPORT_BUTTONS / 8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPDATE_PERIOD = 2'd0,
        CFG_ZERO_REPEAT   = 2'd1,
        CFG_JIGGLE_EN     = 2'd2,
        CFG_KEY_MAP       = 2'd3
    } t_cfg_index;

    typedef enum logic [4:0] {
        PH_INIT  = 5'b00001,
        PH_IDLE  = 5'b00010,
        PH_TRANS = 5'b00100,
        PH_ROT   = 5'b01000,
        PH_KEYS  = 5'b10000
    } t_phase;

    typedef logic [NUM_AXES-1:0][AXIS_W-1:0] t_axes;

    function automatic logic [REPORT_BUTTONS-1:0] map_keys(
        input logic [NUM_KEYS-1:0]  pressed,
        input logic [KEY_MAP_W-1:0] key_map
    );
        logic [REPORT_BUTTONS-1:0] bits;
        logic [KEY_POS_W-1:0]      pos;
        bits = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            pos = key_map[k*KEY_POS_W +: KEY_POS_W];
            if (pressed[k] && (32'(pos) < REPORT_BUTTONS)) begin
                bits = bits | (REPORT_BUTTONS'(1) << pos);
            end
        end
        return bits;
    endfunction

    function automatic logic [PAYLOAD_W-1:0] motion_payload(
        input t_axes axes,
        input logic  jiggle_en,
        input logic  toggle
    );
        logic [PAYLOAD_W-1:0] p;
        logic [AXIS_W-1:0]    v;
        p = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            v = axes[i];
            if (jiggle_en) begin
                v[0] = (axes[i] != '0) && toggle;
            end
            p[i*AXIS_W +: AXIS_W] = v;
        end
        return p;
    endfunction

    function automatic logic [REPEAT_W-1:0] count_zero(
        input logic [REPEAT_W-1:0] count,
        input t_axes               axes,
        input logic [REPEAT_W-1:0] repeat_max
    );
        logic [REPEAT_W-1:0] result;
        result = '0;
        if (axes == '0) begin
            result = (count < repeat_max) ? count + REPEAT_W'(1) : count;
        end
        return result;
    endfunction

endpackage

>>> rtl/hid_motion_report_scheduler.sv
// A result appears on the master side in the cycle after its input transfer.
// Throughput: one input transfer per cycle; each input gives exactly one result transfer.
// The input side stalls only while a held result is not taken by the master side.
// Reset is synchronous and active low: the phase returns to init, timing and counters
// clear, and the configuration registers return to their default values.
`include "hid_motion_report_scheduler_defines.svh"

module hid_motion_report_scheduler
    import hmrs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // now_ms, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z, key_pressed, zero fill.
    input  logic [IN_DATA_W-1:0]    i_s_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // report_length, report_payload, zero fill.
    output logic [OUT_DATA_W-1:0]   o_m_tdata,
    // report_valid, report_id.
    output logic [OUT_USER_W-1:0]   o_m_tuser,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [PERIOD_W-1:0]       r_update_period;
    logic [REPEAT_W-1:0]       r_zero_repeat;
    logic                      r_jiggle_en;
    logic [KEY_MAP_W-1:0]      r_key_map;

    t_phase                    r_phase, n_phase;
    logic [TIME_W-1:0]         r_last, n_last;
    logic [REPEAT_W-1:0]       r_tzc, n_tzc;
    logic [REPEAT_W-1:0]       r_rzc, n_rzc;
    logic [REPORT_BUTTONS-1:0] r_prev_keys, n_prev_keys;
    logic                      r_toggle, n_toggle;

    logic                      r_m_valid;
    logic                      r_rep_valid, n_rep_valid;
    logic [ID_W-1:0]           r_rep_id, n_rep_id;
    logic [LEN_W-1:0]          r_rep_len, n_rep_len;
    logic [PAYLOAD_W-1:0]      r_payload, n_payload;

    logic                      w_accept;
    logic [TIME_W-1:0]         w_now;
    t_axes                     w_trans;
    t_axes                     w_rot;
    logic [NUM_KEYS-1:0]       w_pressed;
    logic [REPORT_BUTTONS-1:0] w_keys;
    logic                      w_keys_changed;
    logic                      w_due;
    logic                      w_motion;

    localparam int TRANS_LO = TIME_W;
    localparam int ROT_LO   = TRANS_LO + NUM_AXES * AXIS_W;
    localparam int KEYS_LO  = ROT_LO + NUM_AXES * AXIS_W;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_m_valid || i_m_tready;
    assign w_accept    = i_s_tvalid && o_s_tready;

    assign w_now     = i_s_tdata[TIME_W-1:0];
    assign w_trans   = i_s_tdata[TRANS_LO +: NUM_AXES*AXIS_W];
    assign w_rot     = i_s_tdata[ROT_LO +: NUM_AXES*AXIS_W];
    assign w_pressed = i_s_tdata[KEYS_LO +: NUM_KEYS];

    assign w_keys         = map_keys(w_pressed, r_key_map);
    assign w_keys_changed = (w_keys != r_prev_keys);
    assign w_due          = (w_now - r_last) >= TIME_W'(r_update_period);
    assign w_motion       = (r_tzc < r_zero_repeat) || (r_rzc < r_zero_repeat)
                            || (w_trans != '0) || (w_rot != '0);

    always_comb begin
        n_phase     = r_phase;
        n_last      = r_last;
        n_tzc       = r_tzc;
        n_rzc       = r_rzc;
        n_prev_keys = r_prev_keys;
        n_toggle    = r_toggle;
        n_rep_valid = 1'b0;
        n_rep_id    = RPT_NONE;
        n_rep_len   = '0;
        n_payload   = '0;
        case (r_phase)
            PH_INIT: begin
                n_last   = w_now;
                n_toggle = 1'b0;
                n_phase  = PH_IDLE;
            end
            PH_IDLE: begin
                if (w_motion) begin
                    n_phase = PH_TRANS;
                end else if (w_keys_changed) begin
                    n_phase = PH_KEYS;
                end else if (w_due) begin
                    n_last = w_now - TIME_W'(r_update_period);
                end
            end
            PH_TRANS: begin
                if (w_due) begin
                    n_rep_valid = 1'b1;
                    n_rep_id    = RPT_TRANS;
                    n_rep_len   = MOTION_LEN;
                    n_payload   = motion_payload(w_trans, r_jiggle_en, r_toggle);
                    n_last      = r_last + TIME_W'(r_update_period);
                    n_tzc       = count_zero(r_tzc, w_trans, r_zero_repeat);
                    n_phase     = PH_ROT;
                end
            end
            PH_ROT: begin
                if (w_due) begin
                    n_rep_valid = 1'b1;
                    n_rep_id    = RPT_ROT;
                    n_rep_len   = MOTION_LEN;
                    n_payload   = motion_payload(w_rot, r_jiggle_en, r_toggle);
                    n_toggle    = r_toggle ^ r_jiggle_en;
                    n_last      = r_last + TIME_W'(r_update_period);
                    n_rzc       = count_zero(r_rzc, w_rot, r_zero_repeat);
                    n_phase     = w_keys_changed ? PH_KEYS : PH_IDLE;
                end
            end
            PH_KEYS: begin
                if (w_due) begin
                    n_rep_valid = 1'b1;
                    n_rep_id    = RPT_KEYS;
                    n_rep_len   = KEYS_LEN;
                    n_payload   = PAYLOAD_W'(w_keys);
                    n_last      = r_last + TIME_W'(r_update_period);
                    n_prev_keys = w_keys;
                    n_phase     = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_period <= RST_UPDATE_PERIOD;
            r_zero_repeat   <= RST_ZERO_REPEAT;
            r_jiggle_en     <= 1'b0;
            r_key_map       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_UPDATE_PERIOD: r_update_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_ZERO_REPEAT:   r_zero_repeat   <= i_cfg_data[REPEAT_W-1:0];
                CFG_JIGGLE_EN:     r_jiggle_en     <= i_cfg_data[0];
                CFG_KEY_MAP:       r_key_map       <= i_cfg_data[KEY_MAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_INIT;
            r_last      <= '0;
            r_tzc       <= '0;
            r_rzc       <= '0;
            r_prev_keys <= '0;
            r_toggle    <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_last      <= n_last;
                r_tzc       <= n_tzc;
                r_rzc       <= n_rzc;
                r_prev_keys <= n_prev_keys;
                r_toggle    <= n_toggle;
                r_m_valid   <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rep_valid <= n_rep_valid;
            r_rep_id    <= n_rep_id;
            r_rep_len   <= n_rep_len;
            r_payload   <= n_payload;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = {r_rep_id, r_rep_valid};
    assign o_m_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), r_payload, r_rep_len};

    `HMRS_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (r_phase == PH_INIT) && (r_last == '0) && !r_m_valid, "Reset did not return the scheduler to init")
    `HMRS_ASSERT(a_trans_to_rot, (w_accept && (r_phase == PH_TRANS) && w_due) |=> (r_phase == PH_ROT) && (r_rep_id == RPT_TRANS), "Sent translation report was not followed by rotation phase")
    `HMRS_ASSERT(a_keys_stored, (w_accept && (r_phase == PH_KEYS) && w_due) |=> (r_phase == PH_IDLE) && (r_prev_keys == r_payload[REPORT_BUTTONS-1:0]), "Keys report did not store the sent key bits")
    `HMRS_ASSERT(a_empty_result, (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0) && (o_m_tuser == '0), "Result without report carries nonzero fields")
    `HMRS_ASSERT(a_idle_no_report, (w_accept && ((r_phase == PH_IDLE) || (r_phase == PH_INIT))) |=> !r_rep_valid, "Report sent from init or idle phase")

endmodule

>>> verif/hmrs_report_checker.sv
`timescale 1ns / 100ps

module hmrs_report_checker
    import hmrs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    input  logic [IN_DATA_W-1:0]    i_s_tdata,
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    input  logic [OUT_DATA_W-1:0]   i_m_tdata,
    input  logic [OUT_USER_W-1:0]   i_m_tuser,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_trans_reports,
    output int                      o_rot_reports,
    output int                      o_keys_reports,
    output int                      o_silent_calls
);

    typedef struct packed {
        logic                 sent;
        logic [ID_W-1:0]      id;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
    } t_report;

    t_report expected_reports[$];

    logic [PERIOD_W-1:0]       update_period;
    logic [REPEAT_W-1:0]       zero_repeat;
    logic                      jiggle_en;
    logic [KEY_MAP_W-1:0]      key_map;

    t_phase                    sched_phase;
    logic [TIME_W-1:0]         last_sent;
    logic [REPEAT_W-1:0]       trans_zeros;
    logic [REPEAT_W-1:0]       rot_zeros;
    logic [REPORT_BUTTONS-1:0] prev_buttons;
    logic                      jiggle_phase;

    int err_cnt     = 0;
    int trans_cnt   = 0;
    int rot_cnt     = 0;
    int keys_cnt    = 0;
    int silent_cnt  = 0;

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic logic [REPORT_BUTTONS-1:0] pressed_to_buttons(
        input logic [NUM_KEYS-1:0] pressed
    );
        logic [REPORT_BUTTONS-1:0] bits;
        logic [KEY_POS_W-1:0]      slot;
        bits = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            slot = key_map[k*KEY_POS_W +: KEY_POS_W];
            if (pressed[k] && (int'(slot) < REPORT_BUTTONS)) begin
                bits[slot] = 1'b1;
            end
        end
        return bits;
    endfunction

    function automatic logic [PAYLOAD_W-1:0] pack_axes(input t_axes a);
        logic [PAYLOAD_W-1:0] p;
        logic [AXIS_W-1:0]    v;
        p = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            v = a[i];
            if (jiggle_en) begin
                v[0] = (|a[i]) & jiggle_phase;
            end
            p[i*AXIS_W +: AXIS_W] = v;
        end
        return p;
    endfunction

    function automatic logic [REPEAT_W-1:0] next_zero_count(
        input logic [REPEAT_W-1:0] c,
        input t_axes               a
    );
        if (a != '0) begin
            return '0;
        end
        return (c < zero_repeat) ? c + REPEAT_W'(1) : c;
    endfunction

    task automatic predict_report(input logic [IN_DATA_W-1:0] d);
        logic [TIME_W-1:0]         now;
        t_axes                     trans;
        t_axes                     rot;
        logic [REPORT_BUTTONS-1:0] buttons;
        logic                      keys_changed;
        logic                      due;
        t_report                   r;
        now          = d[0 +: TIME_W];
        trans        = d[TIME_W +: NUM_AXES*AXIS_W];
        rot          = d[TIME_W + NUM_AXES*AXIS_W +: NUM_AXES*AXIS_W];
        buttons      = pressed_to_buttons(d[TIME_W + 2*NUM_AXES*AXIS_W +: NUM_KEYS]);
        keys_changed = (buttons != prev_buttons);
        due          = ((now - last_sent) >= TIME_W'(update_period));
        r            = '0;
        case (sched_phase)
            PH_INIT: begin
                last_sent    = now;
                jiggle_phase = 1'b0;
                sched_phase  = PH_IDLE;
            end
            PH_IDLE: begin
                if ((trans_zeros < zero_repeat) || (rot_zeros < zero_repeat) ||
                    (trans != '0) || (rot != '0)) begin
                    sched_phase = PH_TRANS;
                end else if (keys_changed) begin
                    sched_phase = PH_KEYS;
                end else if (due) begin
                    last_sent = now - TIME_W'(update_period);
                end
            end
            PH_TRANS: begin
                if (due) begin
                    r.sent      = 1'b1;
                    r.id        = RPT_TRANS;
                    r.len       = MOTION_LEN;
                    r.payload   = pack_axes(trans);
                    last_sent   = last_sent + TIME_W'(update_period);
                    trans_zeros = next_zero_count(trans_zeros, trans);
                    sched_phase = PH_ROT;
                end
            end
            PH_ROT: begin
                if (due) begin
                    r.sent    = 1'b1;
                    r.id      = RPT_ROT;
                    r.len     = MOTION_LEN;
                    r.payload = pack_axes(rot);
                    if (jiggle_en) begin
                        jiggle_phase = ~jiggle_phase;
                    end
                    last_sent   = last_sent + TIME_W'(update_period);
                    rot_zeros   = next_zero_count(rot_zeros, rot);
                    sched_phase = keys_changed ? PH_KEYS : PH_IDLE;
                end
            end
            PH_KEYS: begin
                if (due) begin
                    r.sent       = 1'b1;
                    r.id         = RPT_KEYS;
                    r.len        = KEYS_LEN;
                    r.payload    = PAYLOAD_W'(buttons);
                    last_sent    = last_sent + TIME_W'(update_period);
                    prev_buttons = buttons;
                    sched_phase  = PH_IDLE;
                end
            end
            default: begin
                sched_phase = PH_IDLE;
            end
        endcase
        expected_reports.push_back(r);
    endtask

    task automatic check_report();
        t_report want;
        logic    got_sent;
        logic [ID_W-1:0]      got_id;
        logic [LEN_W-1:0]     got_len;
        logic [PAYLOAD_W-1:0] got_payload;
        got_sent    = i_m_tuser[0];
        got_id      = i_m_tuser[1 +: ID_W];
        got_len     = i_m_tdata[0 +: LEN_W];
        got_payload = i_m_tdata[LEN_W +: PAYLOAD_W];
        if (expected_reports.size() == 0) begin
            report_error($sformatf("result transfer with nothing pending, id %0d", got_id));
        end else begin
            want = expected_reports.pop_front();
            if (got_sent !== want.sent) begin
                report_error($sformatf("report_valid %b, wanted %b", got_sent, want.sent));
            end
            if (got_id !== want.id) begin
                report_error($sformatf("report_id %0d, wanted %0d", got_id, want.id));
            end
            if (got_len !== want.len) begin
                report_error($sformatf("report_length %0d, wanted %0d", got_len, want.len));
            end
            if (got_payload !== want.payload) begin
                report_error($sformatf("report_payload %h, wanted %h",
                                       got_payload, want.payload));
            end
            if (!want.sent) begin
                silent_cnt++;
            end else if (want.id == RPT_TRANS) begin
                trans_cnt++;
            end else if (want.id == RPT_ROT) begin
                rot_cnt++;
            end else begin
                keys_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            update_period = RST_UPDATE_PERIOD;
            zero_repeat   = RST_ZERO_REPEAT;
            jiggle_en     = 1'b0;
            key_map       = '0;
            sched_phase   = PH_INIT;
            last_sent     = '0;
            trans_zeros   = '0;
            rot_zeros     = '0;
            prev_buttons  = '0;
            jiggle_phase  = 1'b0;
            expected_reports.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_report();
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_report(i_s_tdata);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_UPDATE_PERIOD: update_period = i_cfg_data[PERIOD_W-1:0];
                    CFG_ZERO_REPEAT:   zero_repeat   = i_cfg_data[REPEAT_W-1:0];
                    CFG_JIGGLE_EN:     jiggle_en     = i_cfg_data[0];
                    CFG_KEY_MAP:       key_map       = i_cfg_data[KEY_MAP_W-1:0];
                    default: ;
                endcase
            end
        end
        o_errors        <= err_cnt;
        o_pending       <= expected_reports.size();
        o_trans_reports <= trans_cnt;
        o_rot_reports   <= rot_cnt;
        o_keys_reports  <= keys_cnt;
        o_silent_calls  <= silent_cnt;
    end

endmodule

>>> verif/hid_motion_report_scheduler_tb.sv
`timescale 1ns / 100ps

module hid_motion_report_scheduler_tb;
    import hmrs_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int NUM_SETTINGS  = 8;
    localparam int ITEMS_PER_SET = 165;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_s_tvalid  = 1'b0;
    logic                    o_s_tready;
    logic [IN_DATA_W-1:0]    i_s_tdata   = '0;
    logic                    o_m_tvalid;
    logic                    i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_tdata;
    logic [OUT_USER_W-1:0]   o_m_tuser;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_UPDATE_PERIOD;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;

    int err_total;
    int pending_cnt;
    int n_trans;
    int n_rot;
    int n_keys;
    int n_silent;

    logic [TIME_W-1:0]   now_ms_cnt   = '0;
    logic [NUM_KEYS-1:0] keys_held    = '0;
    int                  cur_period   = 8;
    int                  cur_repeat   = 3;
    int                  tx_max       = 5;
    int                  rx_max       = 5;
    int                  rx_stall     = 0;
    int                  rx_draw;
    int                  idle_cycles  = 0;
    int                  calls_sent   = 0;
    int                  settings_cnt = 1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    hid_motion_report_scheduler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    hmrs_report_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_m_tuser       (o_m_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (err_total),
        .o_pending       (pending_cnt),
        .o_trans_reports (n_trans),
        .o_rot_reports   (n_rot),
        .o_keys_reports  (n_keys),
        .o_silent_calls  (n_silent)
    );

    // The report sink stalls for a freshly drawn number of cycles after each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b1;
            rx_stall   <= 0;
        end else if (rx_stall != 0) begin
            rx_stall   <= rx_stall - 1;
            i_m_tready <= (rx_stall == 1);
        end else if (o_m_tvalid && i_m_tready) begin
            rx_draw = $urandom_range(0, rx_max);
            rx_stall   <= rx_draw;
            i_m_tready <= (rx_draw == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [AXIS_W-1:0] draw_axis();
        case ($urandom_range(0, 7))
            0, 1, 2: return '0;
            3:       return 16'h8000;
            4:       return 16'h7FFF;
            5:       return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
            default: return AXIS_W'($urandom);
        endcase
    endfunction

    function automatic t_axes draw_axes(input logic [NUM_AXES-1:0] active);
        t_axes a;
        a = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (active[i]) begin
                a[i] = draw_axis();
            end
        end
        return a;
    endfunction

    function automatic logic [TIME_W-1:0] next_step();
        case ($urandom_range(0, 29))
            0:       return TIME_W'($urandom);
            1:       return '0;
            default: return TIME_W'($urandom_range(0, 2 * cur_period + 1));
        endcase
    endfunction

    task automatic drive_call(
        input logic [TIME_W-1:0]   step,
        input t_axes               trans,
        input t_axes               rot,
        input logic [NUM_KEYS-1:0] keys
    );
        int                   gap;
        logic [IN_DATA_W-1:0] d;
        gap        = $urandom_range(0, tx_max);
        now_ms_cnt = now_ms_cnt + step;
        d          = '0;
        d[0 +: TIME_W]                                    = now_ms_cnt;
        d[TIME_W +: NUM_AXES*AXIS_W]                      = trans;
        d[TIME_W + NUM_AXES*AXIS_W +: NUM_AXES*AXIS_W]    = rot;
        d[TIME_W + 2*NUM_AXES*AXIS_W +: NUM_KEYS]         = keys;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        do @(posedge i_clk); while (!o_s_tready);
        calls_sent++;
    endtask

    // Registers change only once every outstanding report has been taken.
    task automatic load_settings(
        input logic [PERIOD_W-1:0]  period,
        input logic [REPEAT_W-1:0]  zrep,
        input logic                 jig,
        input logic [KEY_MAP_W-1:0] kmap
    );
        t_cfg_index            order [4];
        logic [CFG_DATA_W-1:0] vals  [4];
        order = '{CFG_UPDATE_PERIOD, CFG_ZERO_REPEAT, CFG_JIGGLE_EN, CFG_KEY_MAP};
        vals  = '{CFG_DATA_W'(period), CFG_DATA_W'(zrep), CFG_DATA_W'(jig),
                  CFG_DATA_W'(kmap)};
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (3) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            i_cfg_index <= order[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_period = period;
        cur_repeat = zrep;
        settings_cnt++;
    endtask

    initial begin
        logic [PERIOD_W-1:0]  period;
        logic [REPEAT_W-1:0]  zrep;
        logic [KEY_MAP_W-1:0] kmap;
        logic [NUM_AXES-1:0]  t_active;
        logic [NUM_AXES-1:0]  r_active;
        int                   set_items;
        int                   burst;
        int                   rest;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: start-up, extreme axes, a time wrap, zero counting
        // up to its limit, and every key on the default mapping.
        now_ms_cnt = 32'hFFFF_FFF0;
        drive_call('0, '0, '0, '0);
        drive_call(8, {16'h0001, 16'h8000, 16'h7FFF}, {16'h8000, 16'h0000, 16'hFFFF}, '0);
        drive_call(8, {16'h0001, 16'h8000, 16'h7FFF}, {16'h8000, 16'h0000, 16'hFFFF}, '0);
        drive_call(3, {16'h0001, 16'h8000, 16'h7FFF}, {16'h8000, 16'h0000, 16'hFFFF}, '0);
        drive_call(5, {16'h0001, 16'h8000, 16'h7FFF}, {16'h8000, 16'h0000, 16'hFFFF}, '0);
        repeat (9) drive_call(8, '0, '0, '1);
        repeat (3) drive_call(8, '0, '0, '0);

        // Zero period, no trailing zero reports, jiggle on, spread key mapping.
        kmap = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            kmap[k*KEY_POS_W +: KEY_POS_W] = KEY_POS_W'(31 - 2 * k);
        end
        load_settings('0, '0, 1'b1, kmap);
        repeat (4) drive_call('0, {16'h0000, 16'h0003, 16'h0002},
                              {16'hFFFE, 16'h8001, 16'h0000}, 12'h801);
        repeat (2) drive_call('0, '0, '0, 12'h801);
        repeat (2) drive_call('0, '0, '0, '0);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            case (s % 4)
                0:       period = 8'd1;
                1:       period = 8'd255;
                default: period = PERIOD_W'($urandom_range(2, 40));
            endcase
            case (s % 3)
                0:       zrep = 4'd1;
                1:       zrep = 4'd15;
                default: zrep = REPEAT_W'($urandom_range(1, 15));
            endcase
            kmap = (s == 2) ? '1 : (s == 5) ? '0 : KEY_MAP_W'({$urandom, $urandom});
            load_settings(period, zrep, s[0], kmap);
            tx_max = (s % 3 == 2) ? 0 : 5;
            rx_max <= (s % 3 == 2) ? 0 : 5;
            set_items = 0;
            while (set_items < ITEMS_PER_SET) begin
                if ($urandom_range(0, 9) < 2) begin
                    drive_call(next_step(), draw_axes('1), draw_axes('1),
                               NUM_KEYS'($urandom));
                    set_items++;
                end else begin
                    burst    = $urandom_range(1, 10);
                    t_active = NUM_AXES'($urandom);
                    r_active = NUM_AXES'($urandom);
                    if ($urandom_range(0, 4) == 0) begin
                        keys_held = NUM_KEYS'($urandom);
                    end
                    repeat (burst) drive_call(next_step(), draw_axes(t_active),
                                              draw_axes(r_active), keys_held);
                    rest = $urandom_range(0, 2 * cur_repeat + 4);
                    for (int i = 0; i < rest; i++) begin
                        if ($urandom_range(0, 3) == 0) begin
                            keys_held = NUM_KEYS'($urandom);
                        end
                        drive_call(next_step(), '0, '0, keys_held);
                    end
                    set_items += burst + rest;
                end
            end
        end

        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (4) @(posedge i_clk);
        $display("Ran %0d calls across %0d register settings, with random stalls on both sides.",
                 calls_sent, settings_cnt);
        $display("Checked %0d translation, %0d rotation and %0d key reports and %0d quiet calls.",
                 n_trans, n_rot, n_keys, n_silent);
        if (err_total == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/hmrs_pkg.sv
rtl/hid_motion_report_scheduler.sv
verif/hmrs_report_checker.sv
verif/hid_motion_report_scheduler_tb.sv
